@@ src/lcc_pkg.sv @@
// Shared types, character constants and command codes for the line command classifier.
`timescale 1ns / 1ps

package lcc_pkg;

  // Default line size in bytes; the store keeps one byte less than this.
  localparam int LINE_BYTES_DEF = 32;

  localparam int PASS_DIGITS = 4;
  localparam int TEMP_LEN    = 8;
  localparam int STATUS_LEN  = 10;
  localparam int FAN_LEN     = 10;
  localparam int PASS_LEN    = 9;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_NL  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_0   = 8'h30;
  localparam logic [7:0] CHAR_3   = 8'h33;
  localparam logic [7:0] CHAR_9   = 8'h39;

  localparam logic [79:0] TXT_TEMP   = 80'({"GET", "_TEMP"});
  localparam logic [79:0] TXT_STATUS = 80'({"GET", "_STATUS"});
  localparam logic [79:0] TXT_FAN    = 80'({"FORCE", "_FAN:"});
  localparam logic [79:0] TXT_PASS   = 80'({"SET", "_PASS:"});

  typedef enum logic [2:0] {
    CMD_TEMP_QUERY   = 3'd0,
    CMD_STATUS_QUERY = 3'd1,
    CMD_FAN_OK       = 3'd2,
    CMD_PASS_OK      = 3'd3,
    CMD_FAN_ERR      = 3'd4,
    CMD_PASS_ERR     = 3'd5,
    CMD_UNKNOWN      = 3'd6
  } cmd_t;

  // Per-position compare results, worked out when the byte is written.
  typedef struct packed {
    logic temp;
    logic status;
    logic fan;
    logic pass;
    logic digit;
    logic fan_digit;
  } cell_flags_t;

  // Commands from the top level to every cell of the row.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // Character at position pos of a keyword of length len, NUL past its end.
  function automatic logic [7:0] txt_char(input logic [79:0] s, input int len,
                                          input int pos);
    logic [7:0] c;
    c = CHAR_NUL;
    if (pos < len) begin
      c = s[(len - 1 - pos) * 8 +: 8];
    end
    return c;
  endfunction

endpackage

@@ src/lcc_cell.sv @@
// One byte cell of the line store with its write token and keyword compare flags.
`timescale 1ns / 1ps

module lcc_cell #(
  parameter int POS = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcc_pkg::cell_ctrl_t  ctrl,
  input  logic [7:0]           rx_byte,
  input  logic                 tok_in,
  output logic                 tok_out,
  output logic [7:0]           byte_out,
  output lcc_pkg::cell_flags_t flags_out
);

  logic                 tok_r, tok_nxt;
  logic [7:0]           byte_r;
  lcc_pkg::cell_flags_t flags_r, flags_nxt;

  // The write token marks the next free cell and moves one cell on per stored byte.
  always_comb begin
    tok_nxt = tok_r;
    if (ctrl.clear) begin
      tok_nxt = (POS == 0);
    end else if (ctrl.shift) begin
      tok_nxt = tok_in;
    end
  end

  always_comb begin
    flags_nxt.temp      = (rx_byte == lcc_pkg::txt_char(lcc_pkg::TXT_TEMP,
                                                        lcc_pkg::TEMP_LEN, POS));
    flags_nxt.status    = (rx_byte == lcc_pkg::txt_char(lcc_pkg::TXT_STATUS,
                                                        lcc_pkg::STATUS_LEN, POS));
    flags_nxt.fan       = (rx_byte == lcc_pkg::txt_char(lcc_pkg::TXT_FAN,
                                                        lcc_pkg::FAN_LEN, POS));
    flags_nxt.pass      = (rx_byte == lcc_pkg::txt_char(lcc_pkg::TXT_PASS,
                                                        lcc_pkg::PASS_LEN, POS));
    flags_nxt.digit     = (rx_byte >= lcc_pkg::CHAR_0) && (rx_byte <= lcc_pkg::CHAR_9);
    flags_nxt.fan_digit = (rx_byte >= lcc_pkg::CHAR_0) && (rx_byte <= lcc_pkg::CHAR_3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= (POS == 0);
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift && tok_r) begin
      byte_r  <= rx_byte;
      flags_r <= flags_nxt;
    end
  end

  assign tok_out   = tok_r;
  assign byte_out  = byte_r;
  assign flags_out = flags_r;

endmodule

@@ src/line_command_classifier_core.sv @@
// Top level of the line command classifier: cell row, line tracking and result register.
`timescale 1ns / 1ps

// Usage: one instance per serial channel. Each input item on in_rx_byte is one
// received character; a newline closes the line. Bytes go into a row of
// LINE_BYTES-1 cells, each cell comparing its byte against the keyword
// characters of its position as it is written; further bytes are dropped.
// A non-empty line gives one result item on the out_ ports: the command code,
// the fan level and the four password digits. An empty line gives nothing.
// Ordinary bytes are taken one per cycle while in_stall is low. A newline that
// ends a non-empty line is evaluated in the cycle after it is taken, and its
// result moves into the output register once that register is free;
// in_stall is high only while a line is evaluated. When the receiver stalls,
// the result holds in the output register while the next line is collected;
// if that line ends before the result has gone out, its evaluation and
// in_stall stay up until the output register is free.
// Reset (rst_n low at a clock edge) empties the line and drops any pending
// result; the store contents themselves are not cleared.
module line_command_classifier_core #(
  parameter int LINE_BYTES = lcc_pkg::LINE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_command,
  output logic [1:0] out_fan_level,
  output logic [3:0] out_pass_digit_0,
  output logic [3:0] out_pass_digit_1,
  output logic [3:0] out_pass_digit_2,
  output logic [3:0] out_pass_digit_3
);

  localparam int DEPTH = LINE_BYTES - 1;
  localparam int LEN_W = $clog2(LINE_BYTES);

  logic                 in_acc, is_nl, store_en, line_end, out_load;
  lcc_pkg::cell_ctrl_t  ctrl;
  logic [DEPTH-1:0]     tok;
  logic [7:0]           cell_byte [DEPTH];
  lcc_pkg::cell_flags_t cell_flags [DEPTH];

  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic [LEN_W-1:0] trim_r, trim_nxt;
  logic [LEN_W-1:0] len_r;
  logic             zero_r, zero_nxt;
  logic             eval_r, eval_nxt;

  logic             out_valid_r, out_valid_nxt;
  lcc_pkg::cmd_t    cmd_r, cmd_nxt;
  logic [1:0]       lvl_r, lvl_nxt;
  logic [3:0]       dig_r [lcc_pkg::PASS_DIGITS];
  logic [3:0]       dig_nxt [lcc_pkg::PASS_DIGITS];

  assign in_stall = eval_r;
  assign in_acc   = in_valid & ~in_stall;
  assign is_nl    = (in_rx_byte == lcc_pkg::CHAR_NL);
  assign store_en = in_acc & ~is_nl & (fill_r != LEN_W'(DEPTH));
  assign line_end = in_acc & is_nl;
  // The evaluated line moves into the output register once that register is free.
  assign out_load = eval_r & (~out_valid_r | ~out_stall);

  assign ctrl.shift = store_en;
  assign ctrl.clear = line_end;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lcc_cell #(
      .POS(i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .rx_byte  (in_rx_byte),
      .tok_in   ((i == 0) ? 1'b0 : tok[(i == 0) ? 0 : i - 1]),
      .tok_out  (tok[i]),
      .byte_out (cell_byte[i]),
      .flags_out(cell_flags[i])
    );
  end

  // Text length tracking: it stops at the first zero byte, and trailing
  // carriage returns and spaces never move the trimmed length forward.
  always_comb begin
    fill_nxt = fill_r;
    trim_nxt = trim_r;
    zero_nxt = zero_r;
    eval_nxt = eval_r & ~out_load;
    if (line_end) begin
      fill_nxt = '0;
      trim_nxt = '0;
      zero_nxt = 1'b0;
      eval_nxt = (fill_r != '0);
    end else if (store_en) begin
      fill_nxt = fill_r + 1'b1;
      if (!zero_r) begin
        if (in_rx_byte == lcc_pkg::CHAR_NUL) begin
          zero_nxt = 1'b1;
        end else if ((in_rx_byte != lcc_pkg::CHAR_CR) &&
                     (in_rx_byte != lcc_pkg::CHAR_SP)) begin
          trim_nxt = fill_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      trim_r <= '0;
      zero_r <= 1'b0;
      eval_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      trim_r <= trim_nxt;
      zero_r <= zero_nxt;
      eval_r <= eval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (line_end) begin
      len_r <= trim_r;
    end
  end

  // Classification from the registered per-cell compare flags.
  always_comb begin
    logic temp_m, status_m, fan_m, pass_m, digits_m;
    temp_m   = 1'b1;
    status_m = 1'b1;
    fan_m    = 1'b1;
    pass_m   = 1'b1;
    digits_m = 1'b1;
    for (int i = 0; i < lcc_pkg::TEMP_LEN; i++) begin
      temp_m = temp_m & cell_flags[i].temp;
    end
    for (int i = 0; i < lcc_pkg::STATUS_LEN; i++) begin
      status_m = status_m & cell_flags[i].status;
    end
    for (int i = 0; i < lcc_pkg::FAN_LEN; i++) begin
      fan_m = fan_m & cell_flags[i].fan;
    end
    for (int i = 0; i < lcc_pkg::PASS_LEN; i++) begin
      pass_m = pass_m & cell_flags[i].pass;
    end
    for (int i = 0; i < lcc_pkg::PASS_DIGITS; i++) begin
      digits_m = digits_m & cell_flags[lcc_pkg::PASS_LEN + i].digit;
    end

    cmd_nxt = lcc_pkg::CMD_UNKNOWN;
    lvl_nxt = '0;
    for (int i = 0; i < lcc_pkg::PASS_DIGITS; i++) begin
      dig_nxt[i] = '0;
    end

    if ((len_r == LEN_W'(lcc_pkg::TEMP_LEN)) && temp_m) begin
      cmd_nxt = lcc_pkg::CMD_TEMP_QUERY;
    end else if ((len_r == LEN_W'(lcc_pkg::STATUS_LEN)) && status_m) begin
      cmd_nxt = lcc_pkg::CMD_STATUS_QUERY;
    end else if ((len_r >= LEN_W'(lcc_pkg::FAN_LEN)) && fan_m) begin
      if ((len_r > LEN_W'(lcc_pkg::FAN_LEN)) && cell_flags[lcc_pkg::FAN_LEN].fan_digit) begin
        cmd_nxt = lcc_pkg::CMD_FAN_OK;
        lvl_nxt = cell_byte[lcc_pkg::FAN_LEN][1:0];
      end else begin
        cmd_nxt = lcc_pkg::CMD_FAN_ERR;
      end
    end else if ((len_r >= LEN_W'(lcc_pkg::PASS_LEN)) && pass_m) begin
      if ((len_r == LEN_W'(lcc_pkg::PASS_LEN + lcc_pkg::PASS_DIGITS)) && digits_m) begin
        cmd_nxt = lcc_pkg::CMD_PASS_OK;
        for (int i = 0; i < lcc_pkg::PASS_DIGITS; i++) begin
          dig_nxt[i] = cell_byte[lcc_pkg::PASS_LEN + i][3:0];
        end
      end else begin
        cmd_nxt = lcc_pkg::CMD_PASS_ERR;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cmd_r <= cmd_nxt;
      lvl_r <= lvl_nxt;
      dig_r <= dig_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_command      = cmd_r;
  assign out_fan_level    = lvl_r;
  assign out_pass_digit_0 = dig_r[0];
  assign out_pass_digit_1 = dig_r[1];
  assign out_pass_digit_2 = dig_r[2];
  assign out_pass_digit_3 = dig_r[3];

  // The write token sits on the cell indexed by the fill count, or nowhere when full.
  a_tok_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok) && ((tok == '0) == (fill_r == LEN_W'(DEPTH))))
    else $error("write token out of step with fill count");

  a_trim_fill: assert property (@(posedge clk) disable iff (!rst_n)
    trim_r <= fill_r)
    else $error("trimmed length beyond stored bytes");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(cmd_r) && $stable(lvl_r)))
    else $error("stalled result changed or was dropped");

  a_nl_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (line_end && (fill_r == '0)) |=> !eval_r)
    else $error("empty line started an evaluation");

  a_fan_lvl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (cmd_r != lcc_pkg::CMD_FAN_OK)) |-> (lvl_r == '0))
    else $error("fan level set without fan command");

endmodule

@@ tb/tb_line_command_classifier_core.sv @@
// Self-checking testbench for the line command classifier core: directed and random lines.
`timescale 1ns / 1ps

module tb_line_command_classifier_core;

  localparam int STORE_DEPTH  = lcc_pkg::LINE_BYTES_DEF - 1;
  localparam int RANDOM_BYTES = 1340;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;
  // In a directed row an '@' is sent as a zero byte, since a string cannot hold one.
  localparam logic [7:0] NUL_MARK = 8'h40;

  typedef struct packed {
    lcc_pkg::cmd_t command;
    logic [1:0]    fan_level;
    logic [3:0]    digit_0;
    logic [3:0]    digit_1;
    logic [3:0]    digit_2;
    logic [3:0]    digit_3;
  } line_result_t;

  typedef enum int {
    ROW_PREDICTED,
    ROW_NO_RESULT,
    ROW_TYPED
  } row_kind_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_command;
  logic [1:0] out_fan_level;
  logic [3:0] out_pass_digit_0;
  logic [3:0] out_pass_digit_1;
  logic [3:0] out_pass_digit_2;
  logic [3:0] out_pass_digit_3;

  line_command_classifier_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command      (out_command),
    .out_fan_level    (out_fan_level),
    .out_pass_digit_0 (out_pass_digit_0),
    .out_pass_digit_1 (out_pass_digit_1),
    .out_pass_digit_2 (out_pass_digit_2),
    .out_pass_digit_3 (out_pass_digit_3)
  );

  string kw_temp   = {"GET", "_TEMP"};
  string kw_status = {"GET", "_STATUS"};
  string kw_fan    = {"FORCE", "_FAN:"};
  string kw_pass   = {"SET", "_PASS:"};

  // Shadow copy of the line being collected.
  logic [7:0] line_buf [STORE_DEPTH];
  int         line_fill = 0;

  line_result_t exp_q [$];
  logic [7:0]   line_bytes [$];
  string        dir_txt [$];
  row_kind_t    dir_kind [$];
  line_result_t dir_res [$];

  row_kind_t    row_kind = ROW_PREDICTED;
  line_result_t typed_res = '0;

  int send_idle_pct = 13;
  int recv_idle_pct = 59;
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rand_sent = 0;
  int errors = 0;
  int cycle_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic line_result_t mk_res(input lcc_pkg::cmd_t c, input logic [1:0] lvl,
                                          input logic [3:0] d0, input logic [3:0] d1,
                                          input logic [3:0] d2, input logic [3:0] d3);
    line_result_t r;
    r.command   = c;
    r.fan_level = lvl;
    r.digit_0   = d0;
    r.digit_1   = d1;
    r.digit_2   = d2;
    r.digit_3   = d3;
    return r;
  endfunction

  function automatic bit starts_with(input string kw, input int len);
    bit ok;
    ok = (len >= kw.len());
    for (int i = 0; ok && i < kw.len(); i++) begin
      ok = (line_buf[i] == kw[i]);
    end
    return ok;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= lcc_pkg::CHAR_0 && c <= lcc_pkg::CHAR_9;
  endfunction

  // Takes one byte into the shadow line; returns 1 when a newline closes a
  // non-empty line, with the classified command in res.
  function automatic bit classify_byte(input logic [7:0] b, output line_result_t res);
    int  len;
    bit  ok;
    res = mk_res(lcc_pkg::CMD_UNKNOWN, 2'd0, 4'd0, 4'd0, 4'd0, 4'd0);
    if (b != lcc_pkg::CHAR_NL) begin
      if (line_fill < STORE_DEPTH) begin
        line_buf[line_fill] = b;
        line_fill++;
      end
      return 1'b0;
    end
    if (line_fill == 0) begin
      return 1'b0;
    end
    len = 0;
    while (len < line_fill && line_buf[len] != lcc_pkg::CHAR_NUL) begin
      len++;
    end
    while (len > 0 && (line_buf[len - 1] == lcc_pkg::CHAR_CR ||
                       line_buf[len - 1] == lcc_pkg::CHAR_SP)) begin
      len--;
    end
    line_fill = 0;
    if (len == lcc_pkg::TEMP_LEN && starts_with(kw_temp, len)) begin
      res.command = lcc_pkg::CMD_TEMP_QUERY;
    end else if (len == lcc_pkg::STATUS_LEN && starts_with(kw_status, len)) begin
      res.command = lcc_pkg::CMD_STATUS_QUERY;
    end else if (starts_with(kw_fan, len)) begin
      if (len > lcc_pkg::FAN_LEN && line_buf[lcc_pkg::FAN_LEN] >= lcc_pkg::CHAR_0 &&
          line_buf[lcc_pkg::FAN_LEN] <= lcc_pkg::CHAR_3) begin
        res.command   = lcc_pkg::CMD_FAN_OK;
        res.fan_level = 2'(line_buf[lcc_pkg::FAN_LEN] - lcc_pkg::CHAR_0);
      end else begin
        res.command = lcc_pkg::CMD_FAN_ERR;
      end
    end else if (starts_with(kw_pass, len)) begin
      ok = (len == lcc_pkg::PASS_LEN + lcc_pkg::PASS_DIGITS);
      for (int i = 0; ok && i < lcc_pkg::PASS_DIGITS; i++) begin
        ok = is_digit(line_buf[lcc_pkg::PASS_LEN + i]);
      end
      if (ok) begin
        res.command = lcc_pkg::CMD_PASS_OK;
        res.digit_0 = 4'(line_buf[lcc_pkg::PASS_LEN] - lcc_pkg::CHAR_0);
        res.digit_1 = 4'(line_buf[lcc_pkg::PASS_LEN + 1] - lcc_pkg::CHAR_0);
        res.digit_2 = 4'(line_buf[lcc_pkg::PASS_LEN + 2] - lcc_pkg::CHAR_0);
        res.digit_3 = 4'(line_buf[lcc_pkg::PASS_LEN + 3] - lcc_pkg::CHAR_0);
      end else begin
        res.command = lcc_pkg::CMD_PASS_ERR;
      end
    end
    return 1'b1;
  endfunction

  task automatic add_row(input string txt, input row_kind_t kind, input line_result_t res);
    dir_txt.push_back(txt);
    dir_kind.push_back(kind);
    dir_res.push_back(res);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b == lcc_pkg::CHAR_NL);
    return b;
  endfunction

  function automatic string pick_keyword();
    string s;
    case ($urandom_range(3))
      0:       s = kw_temp;
      1:       s = kw_status;
      2:       s = kw_fan;
      default: s = kw_pass;
    endcase
    return s;
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      line_bytes.push_back(s[i]);
    end
  endtask

  task automatic pad_trailing();
    repeat ($urandom_range(3)) begin
      line_bytes.push_back($urandom_range(1) ? lcc_pkg::CHAR_SP : lcc_pkg::CHAR_CR);
    end
  endtask

  // Half the lines start as commands with random arguments, the rest are noise and broken lines.
  task automatic build_random_line();
    int n;
    line_bytes.delete();
    case ($urandom_range(9))
      0: begin
        push_text($urandom_range(1) ? kw_temp : kw_status);
        pad_trailing();
      end
      1, 2: begin
        push_text(kw_fan);
        if ($urandom_range(9) != 0) begin
          line_bytes.push_back($urandom_range(3) != 0
                               ? 8'(lcc_pkg::CHAR_0 + $urandom_range(3)) : text_byte());
        end
        repeat ($urandom_range(3)) line_bytes.push_back(text_byte());
      end
      3, 4: begin
        push_text(kw_pass);
        n = ($urandom_range(9) < 7) ? lcc_pkg::PASS_DIGITS : $urandom_range(6);
        repeat (n) begin
          line_bytes.push_back($urandom_range(9) != 0
                               ? 8'(lcc_pkg::CHAR_0 + $urandom_range(9)) : text_byte());
        end
        if ($urandom_range(3) == 0) pad_trailing();
      end
      5: begin
        push_text(pick_keyword());
        line_bytes[$urandom_range(line_bytes.size() - 1)] = text_byte();
      end
      6: begin
        repeat ($urandom_range(20)) line_bytes.push_back(8'($urandom_range(255)));
      end
      7: begin
        // Can run past the end of the store.
        push_text(pick_keyword());
        repeat ($urandom_range(34, 20)) begin
          line_bytes.push_back($urandom_range(3) != 0 ? lcc_pkg::CHAR_SP : text_byte());
        end
      end
      8: begin
        push_text(pick_keyword());
        line_bytes.push_back(lcc_pkg::CHAR_NUL);
        repeat ($urandom_range(4)) line_bytes.push_back(text_byte());
      end
      default: pad_trailing();
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    line_result_t res;
    bit           got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = classify_byte(b, res);
    if (b == lcc_pkg::CHAR_NL && row_kind != ROW_PREDICTED) begin
      if (row_kind == ROW_TYPED) exp_q.push_back(typed_res);
    end else if (got) begin
      exp_q.push_back(res);
    end
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) send_byte(line_bytes[i]);
    send_byte(lcc_pkg::CHAR_NL);
  endtask

  // Receiver: random stalls, or one long hold-off when asked for.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_ask) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_seen <= hold_ask;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    line_result_t got;
    line_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = mk_res(lcc_pkg::cmd_t'(out_command), out_fan_level, out_pass_digit_0,
                   out_pass_digit_1, out_pass_digit_2, out_pass_digit_3);
      if (exp_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("Unexpected result: command %0d level %0d digits %0d %0d %0d %0d",
                   got.command, got.fan_level, got.digit_0, got.digit_1, got.digit_2,
                   got.digit_3);
        end
      end else begin
        want = exp_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("Mismatch: expected command %0d level %0d digits %0d %0d %0d %0d",
                     want.command, want.fan_level, want.digit_0, want.digit_1,
                     want.digit_2, want.digit_3);
            $display("          actual   command %0d level %0d digits %0d %0d %0d %0d",
                     got.command, got.fan_level, got.digit_0, got.digit_1, got.digit_2,
                     got.digit_3);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    string        row_txt;
    line_result_t none;
    none = mk_res(lcc_pkg::CMD_UNKNOWN, 2'd0, 4'd0, 4'd0, 4'd0, 4'd0);

    add_row(kw_temp, ROW_TYPED,
            mk_res(lcc_pkg::CMD_TEMP_QUERY, 2'd0, 4'd0, 4'd0, 4'd0, 4'd0));
    add_row(kw_status, ROW_TYPED,
            mk_res(lcc_pkg::CMD_STATUS_QUERY, 2'd0, 4'd0, 4'd0, 4'd0, 4'd0));
    add_row({kw_fan, "0"}, ROW_TYPED,
            mk_res(lcc_pkg::CMD_FAN_OK, 2'd0, 4'd0, 4'd0, 4'd0, 4'd0));
    add_row({kw_fan, "3xyz"}, ROW_TYPED,
            mk_res(lcc_pkg::CMD_FAN_OK, 2'd3, 4'd0, 4'd0, 4'd0, 4'd0));
    add_row({kw_fan, "4"}, ROW_TYPED,
            mk_res(lcc_pkg::CMD_FAN_ERR, 2'd0, 4'd0, 4'd0, 4'd0, 4'd0));
    add_row(kw_fan, ROW_TYPED,
            mk_res(lcc_pkg::CMD_FAN_ERR, 2'd0, 4'd0, 4'd0, 4'd0, 4'd0));
    add_row({kw_pass, "0000"}, ROW_TYPED,
            mk_res(lcc_pkg::CMD_PASS_OK, 2'd0, 4'd0, 4'd0, 4'd0, 4'd0));
    add_row({kw_pass, "9876"}, ROW_TYPED,
            mk_res(lcc_pkg::CMD_PASS_OK, 2'd0, 4'd9, 4'd8, 4'd7, 4'd6));
    add_row({kw_pass, "123"}, ROW_TYPED,
            mk_res(lcc_pkg::CMD_PASS_ERR, 2'd0, 4'd0, 4'd0, 4'd0, 4'd0));
    add_row({kw_pass, "12345"}, ROW_TYPED,
            mk_res(lcc_pkg::CMD_PASS_ERR, 2'd0, 4'd0, 4'd0, 4'd0, 4'd0));
    add_row({kw_pass, "12a4"}, ROW_TYPED,
            mk_res(lcc_pkg::CMD_PASS_ERR, 2'd0, 4'd0, 4'd0, 4'd0, 4'd0));
    add_row("", ROW_NO_RESULT, none);
    add_row("  \015 \015", ROW_TYPED, none);
    add_row({kw_status, " \015"}, ROW_TYPED,
            mk_res(lcc_pkg::CMD_STATUS_QUERY, 2'd0, 4'd0, 4'd0, 4'd0, 4'd0));
    add_row({kw_temp, "@\377"}, ROW_TYPED,
            mk_res(lcc_pkg::CMD_TEMP_QUERY, 2'd0, 4'd0, 4'd0, 4'd0, 4'd0));
    add_row({"@", kw_temp}, ROW_TYPED, none);
    add_row({kw_temp, "S"}, ROW_TYPED, none);
    add_row({kw_fan, "2 "}, ROW_PREDICTED, none);
    add_row({kw_fan, " 1"}, ROW_PREDICTED, none);
    add_row({kw_pass, "1234\015"}, ROW_PREDICTED, none);
    add_row({kw_temp, "                        XYZ"}, ROW_PREDICTED, none);
    add_row({kw_pass, "1234567890123456789012345678901"}, ROW_PREDICTED, none);
    add_row("\001\177\200\377", ROW_PREDICTED, none);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < dir_txt.size(); r++) begin
      row_txt = dir_txt[r];
      line_bytes.delete();
      for (int i = 0; i < row_txt.len(); i++) begin
        line_bytes.push_back(row_txt[i] == NUL_MARK ? lcc_pkg::CHAR_NUL : 8'(row_txt[i]));
      end
      row_kind  = dir_kind[r];
      typed_res = dir_res[r];
      send_line();
    end
    row_kind = ROW_PREDICTED;

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // The receiver holds off for a long stretch while lines keep coming.
          hold_ask = hold_ask + 1;
        end
      endcase
      while (rand_sent < (p + 1) * RANDOM_BYTES / 3) begin
        build_random_line();
        send_line();
        rand_sent += line_bytes.size() + 1;
      end
    end
    in_valid <= 1'b0;

    while (exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && exp_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/lcc_pkg.sv
src/lcc_cell.sv
src/line_command_classifier_core.sv
tb/tb_line_command_classifier_core.sv
